### rtl/lar_pkg.sv
// Package for the link autonegotiation resolver: types, codes and register masks.
`timescale 1ns / 1ps
package lar_pkg;

  localparam int unsigned LinkFailBitDefault = 4;

  localparam int unsigned AdvW   = 9;
  localparam int unsigned CfgIdxW = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ADVERTISE  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_MEDIA_LOCK = 1'd1;

  localparam logic [AdvW-1:0] ADV_RESET = 9'h1E0;

  // port codes
  localparam logic [2:0] PORT_10HD  = 3'd0;
  localparam logic [2:0] PORT_100HD = 3'd3;
  localparam logic [2:0] PORT_10FD  = 3'd4;
  localparam logic [2:0] PORT_100FD = 3'd5;

  // rx/tx action codes
  localparam logic [1:0] RXTX_NONE    = 2'd0;
  localparam logic [1:0] RXTX_START   = 2'd1;
  localparam logic [1:0] RXTX_RESTART = 2'd2;

  localparam logic [2:0] NWAY_DONE = 3'b101;
  localparam logic [2:0] NWAY_KICK = 3'b001;

  localparam logic [31:0] AN_KEEP     = 32'hfff0_ee39;
  localparam logic [31:0] AN_ENABLES  = 32'h0000_1184;
  localparam logic [31:0] AN_OFF_MASK = 32'hffff_ff7f;
  localparam logic [31:0] AN_ADV_100FD = 32'h0002_0000;
  localparam logic [31:0] AN_ADV_100HD = 32'h0001_0000;
  localparam logic [31:0] AN_ADV_10HD  = 32'h0000_0040;
  localparam logic [31:0] MODE_KEEP   = 32'hfe3b_d1fd;
  localparam logic [31:0] MODE_NWAY   = 32'h0100_0000;
  localparam logic [31:0] MODE_100    = 32'h0184_0000;
  localparam logic [31:0] MODE_10     = 32'h0040_0000;
  localparam logic [31:0] MODE_FD     = 32'h0000_0200;
  localparam logic [31:0] PHY_KEEP    = 32'hffff_8fff;
  localparam logic [31:0] PHY_KICK    = 32'h0000_1000;
  localparam int unsigned ISR_LNKCHG_BIT = 27;

  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 112;

  typedef struct packed {
    logic        operation;
    logic [31:0] interrupt_status;
    logic [31:0] phy_status;
    logic [31:0] mode_readback;
    logic [31:0] autoneg_readback;
  } item_t;

  typedef struct packed {
    logic [AdvW-1:0] advertise_mask;
    logic            media_lock;
  } cfg_t;

  typedef struct packed {
    logic [2:0] port_sel;
    logic       negotiating;
    logic       resolved;
    logic       full_dup;
  } state_t;

  typedef struct packed {
    logic [2:0]  port_out;
    logic        duplex_out;
    logic        autoneg_write;
    logic [31:0] autoneg_value;
    logic        mode_write;
    logic [31:0] mode_value;
    logic        phy_write;
    logic [31:0] phy_value;
    logic        sia_reset_write;
    logic [1:0]  rxtx_action;
    logic        rearm_timer;
  } result_t;

endpackage

### rtl/link_autoneg_resolver.sv
// Top level: input stage, link state registers, decision logic and result register.
// An accepted word is held in the input stage, then moves to the result register.
// Throughput: one word per cycle while out_tready is high. Input stage and result
// register form a two-deep pipeline; one more word enters while a result waits.
// Reset (rst_n low, synchronous): link state cleared, advertise mask 0x1E0,
// media lock off, both pipeline stages emptied.
`timescale 1ns / 1ps
module link_autoneg_resolver #(
  parameter int unsigned LINK_FAIL_BIT = lar_pkg::LinkFailBitDefault
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // interrupt_status, phy_status, mode_readback, autoneg_readback
  input  logic [lar_pkg::InDataW-1:0]     in_tdata,
  // operation
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // port_out, duplex_out, autoneg_write, autoneg_value, mode_write, mode_value,
  // phy_write, phy_value, sia_reset_write, rxtx_action, rearm_timer, zero pad
  output logic [lar_pkg::OutDataW-1:0]    out_tdata,
  input  logic                            cfg_we,
  input  logic [lar_pkg::CfgIdxW-1:0]     cfg_addr,
  input  logic [lar_pkg::AdvW-1:0]        cfg_wdata
);

  lar_pkg::item_t   item_r;
  lar_pkg::item_t   item_nxt;
  logic             s1_valid_r;
  logic             s1_adv;
  lar_pkg::cfg_t    cfg_r;
  lar_pkg::state_t  state_r;
  lar_pkg::state_t  state_nxt;
  lar_pkg::result_t res_nxt;
  lar_pkg::result_t out_r;
  logic             out_valid_r;

  assign item_nxt.operation        = in_tuser;
  assign item_nxt.interrupt_status = in_tdata[31:0];
  assign item_nxt.phy_status       = in_tdata[63:32];
  assign item_nxt.mode_readback    = in_tdata[95:64];
  assign item_nxt.autoneg_readback = in_tdata[127:96];

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  lar_core #(
    .LINK_FAIL_BIT(LINK_FAIL_BIT)
  ) u_core (
    .item  (item_r),
    .cfg   (cfg_r),
    .st    (state_r),
    .st_nxt(state_nxt),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.advertise_mask <= lar_pkg::ADV_RESET;
      cfg_r.media_lock     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        lar_pkg::REG_ADVERTISE:  cfg_r.advertise_mask <= cfg_wdata;
        lar_pkg::REG_MEDIA_LOCK: cfg_r.media_lock     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
    if (s1_adv) begin
      out_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_r.rearm_timer, out_r.rxtx_action, out_r.sia_reset_write,
                       out_r.phy_value, out_r.phy_write, out_r.mode_value, out_r.mode_write,
                       out_r.autoneg_value, out_r.autoneg_write, out_r.duplex_out,
                       out_r.port_out};

  // link state holds a defined port code at all times
  a_port_code: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.port_sel == lar_pkg::PORT_10HD) || (state_r.port_sel == lar_pkg::PORT_100HD) ||
    (state_r.port_sel == lar_pkg::PORT_10FD) || (state_r.port_sel == lar_pkg::PORT_100FD))
    else $error("port_sel holds an undefined code");

  // state moves only when a word passes into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(state_r))
    else $error("link state changed without a word");

  // a negotiation kick always carries state 001 in the PHY write
  a_kick_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.phy_write |-> out_r.phy_value[14:12] == lar_pkg::NWAY_KICK)
    else $error("PHY kick value malformed");

  // timer rearm only comes with a full restart
  a_rearm_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.rearm_timer |-> out_r.phy_write && out_r.autoneg_write &&
    out_r.mode_write && (out_r.rxtx_action == lar_pkg::RXTX_NONE))
    else $error("timer rearm without restart");

  // both stages full and output stalled: input side must stall
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input accepted into a full pipeline");

endmodule

### rtl/lar_core.sv
// Decision logic: next link state and register writes for one event word.
`timescale 1ns / 1ps
module lar_core #(
  parameter int unsigned LINK_FAIL_BIT = lar_pkg::LinkFailBitDefault
) (
  input  lar_pkg::item_t   item,
  input  lar_pkg::cfg_t    cfg,
  input  lar_pkg::state_t  st,
  output lar_pkg::state_t  st_nxt,
  output lar_pkg::result_t res
);

  logic [3:0]  common;
  logic        port_ok;
  logic        port_100;
  logic        restart;
  logic        beat_fail;
  logic        begin_neg;
  logic        fall_back;
  logic        rearm;
  logic [31:0] an_begin;
  logic [31:0] md_begin;
  logic [31:0] md_resolve;
  logic [31:0] isr;
  logic [31:0] phy;

  assign isr = item.interrupt_status;
  assign phy = item.phy_status;

  // partner abilities aligned with advertise bits 8:5
  assign common = phy[24:21] & cfg.advertise_mask[8:5];

  assign port_100 = (st.port_sel == lar_pkg::PORT_100HD) ||
                    (st.port_sel == lar_pkg::PORT_100FD);
  assign port_ok  = port_100 || (st.port_sel == lar_pkg::PORT_10HD) ||
                    (st.port_sel == lar_pkg::PORT_10FD);

  assign restart = (st.resolved && isr[lar_pkg::ISR_LNKCHG_BIT] && port_100 && phy[1]) ||
                   (st.negotiating && isr[LINK_FAIL_BIT]);
  assign beat_fail = port_100 ? phy[1] : phy[2];

  assign an_begin = (item.autoneg_readback & lar_pkg::AN_KEEP) | lar_pkg::AN_ENABLES |
                    (cfg.advertise_mask[8] ? lar_pkg::AN_ADV_100FD : 32'd0) |
                    (cfg.advertise_mask[7] ? lar_pkg::AN_ADV_100HD : 32'd0) |
                    (cfg.advertise_mask[5] ? lar_pkg::AN_ADV_10HD  : 32'd0);
  assign md_begin = (item.mode_readback & lar_pkg::MODE_KEEP) | lar_pkg::MODE_NWAY |
                    (cfg.advertise_mask[6] ? lar_pkg::MODE_FD : 32'd0);

  always_comb begin
    st_nxt     = st;
    res        = '0;
    begin_neg  = 1'b0;
    fall_back  = 1'b0;
    rearm      = 1'b0;
    md_resolve = '0;
    if (!item.operation) begin
      begin_neg = 1'b1;
    end else if (st.negotiating && !st.resolved) begin
      if (phy[14:12] == lar_pkg::NWAY_DONE) begin
        st_nxt.resolved = 1'b1;
        if (common[3]) begin
          st_nxt.port_sel = lar_pkg::PORT_100FD;
        end else if (common[2]) begin
          st_nxt.port_sel = lar_pkg::PORT_100HD;
        end else if (common[1]) begin
          st_nxt.port_sel = lar_pkg::PORT_10FD;
        end else if (common[0]) begin
          st_nxt.port_sel = lar_pkg::PORT_10HD;
        end else begin
          // no common ability: stay unresolved
          st_nxt.resolved = 1'b0;
          if (!phy[1] && (|cfg.advertise_mask[8:7])) begin
            st_nxt.port_sel = lar_pkg::PORT_100HD;
          end
        end
        st_nxt.full_dup = (st_nxt.port_sel == lar_pkg::PORT_10FD) ||
                          (st_nxt.port_sel == lar_pkg::PORT_100FD);
        md_resolve = (item.mode_readback & lar_pkg::MODE_KEEP) |
                     (st_nxt.port_sel[0] ? lar_pkg::MODE_100 : lar_pkg::MODE_10) |
                     (st_nxt.full_dup ? lar_pkg::MODE_FD : 32'd0);
        res.autoneg_write   = 1'b1;
        res.autoneg_value   = item.autoneg_readback & lar_pkg::AN_OFF_MASK;
        res.mode_write      = 1'b1;
        res.mode_value      = md_resolve;
        res.sia_reset_write = 1'b1;
        res.rxtx_action     = lar_pkg::RXTX_START;
      end else begin
        st_nxt.port_sel    = lar_pkg::PORT_10HD;
        st_nxt.negotiating = 1'b0;
        st_nxt.resolved    = 1'b1;
        fall_back          = 1'b1;
      end
    end else if (restart) begin
      begin_neg = 1'b1;
      rearm     = 1'b1;
    end else if (port_ok) begin
      st_nxt.negotiating = 1'b0;
      st_nxt.resolved    = 1'b1;
      if (beat_fail && !cfg.media_lock) begin
        begin_neg = 1'b1;
        rearm     = 1'b1;
      end
    end else begin
      // undefined port code
      st_nxt.port_sel = lar_pkg::PORT_10HD;
      fall_back       = 1'b1;
    end

    if (begin_neg) begin
      st_nxt.port_sel    = lar_pkg::PORT_10HD;
      st_nxt.negotiating = 1'b1;
      st_nxt.resolved    = 1'b0;
      res.autoneg_write  = 1'b1;
      res.autoneg_value  = an_begin;
      res.mode_write     = 1'b1;
      res.mode_value     = md_begin;
      res.phy_write      = 1'b1;
      res.phy_value      = (phy & lar_pkg::PHY_KEEP) | lar_pkg::PHY_KICK;
    end
    if (fall_back) begin
      res.autoneg_write = 1'b1;
      res.autoneg_value = item.autoneg_readback & lar_pkg::AN_OFF_MASK;
      res.mode_write    = 1'b1;
      res.mode_value    = (item.mode_readback & lar_pkg::MODE_KEEP) | lar_pkg::MODE_10;
      res.rxtx_action   = lar_pkg::RXTX_RESTART;
    end
    res.rearm_timer = rearm;
    res.port_out    = st_nxt.port_sel;
    res.duplex_out  = st_nxt.full_dup;
  end

endmodule

### sim/tb_link_autoneg_resolver.sv
// Testbench for link_autoneg_resolver: directed and random link events checked against a predictor.
`timescale 1ns / 1ps
module tb_link_autoneg_resolver;

  localparam logic OP_START = 1'b0;
  localparam logic OP_LINK  = 1'b1;
  localparam int unsigned FAIL_BIT = lar_pkg::LinkFailBitDefault;

  class autoneg_checker;
    logic [lar_pkg::AdvW-1:0] adv_mask;
    logic                     lock;
    logic [2:0]               port_sel;
    logic                     negotiating;
    logic                     resolved;
    logic                     full_dup;
    lar_pkg::result_t         expected_writes[$];
    int                       errors;
    int                       results_checked;

    function new();
      adv_mask = lar_pkg::ADV_RESET;
      lock = 1'b0;
      port_sel = lar_pkg::PORT_10HD;
      negotiating = 1'b0;
      resolved = 1'b0;
      full_dup = 1'b0;
      errors = 0;
      results_checked = 0;
    endfunction

    function void set_reg(logic [lar_pkg::CfgIdxW-1:0] idx, logic [lar_pkg::AdvW-1:0] val);
      if (idx == lar_pkg::REG_ADVERTISE) adv_mask = val;
      else if (idx == lar_pkg::REG_MEDIA_LOCK) lock = val[0];
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction

    function void restart_nway(logic [31:0] an_rb, logic [31:0] mode_rb, logic [31:0] phy,
                               inout lar_pkg::result_t r);
      logic [31:0] an;
      logic [31:0] md;
      an = an_rb & lar_pkg::AN_KEEP;
      if (adv_mask[8]) an |= lar_pkg::AN_ADV_100FD;
      if (adv_mask[7]) an |= lar_pkg::AN_ADV_100HD;
      if (adv_mask[5]) an |= lar_pkg::AN_ADV_10HD;
      an |= lar_pkg::AN_ENABLES;
      md = mode_rb & lar_pkg::MODE_KEEP;
      if (adv_mask[6]) md |= lar_pkg::MODE_FD;
      md |= lar_pkg::MODE_NWAY;
      port_sel = lar_pkg::PORT_10HD;
      negotiating = 1'b1;
      resolved = 1'b0;
      r.autoneg_write = 1'b1;
      r.autoneg_value = an;
      r.mode_write = 1'b1;
      r.mode_value = md;
      r.phy_write = 1'b1;
      r.phy_value = (phy & lar_pkg::PHY_KEEP) | lar_pkg::PHY_KICK;
    endfunction

    function void drop_to_10hd(logic [31:0] an_rb, logic [31:0] mode_rb,
                               inout lar_pkg::result_t r);
      r.autoneg_write = 1'b1;
      r.autoneg_value = an_rb & lar_pkg::AN_OFF_MASK;
      r.mode_write = 1'b1;
      r.mode_value = (mode_rb & lar_pkg::MODE_KEEP) | lar_pkg::MODE_10;
      r.rxtx_action = lar_pkg::RXTX_RESTART;
    endfunction

    function void predict_event(logic op, logic [31:0] isr, logic [31:0] phy,
                                logic [31:0] mode_rb, logic [31:0] an_rb);
      lar_pkg::result_t r;
      logic [8:0]       common;
      logic [31:0]      md;
      logic             is100;
      logic             beat_fail;
      r = '0;
      is100 = (port_sel == lar_pkg::PORT_100HD) || (port_sel == lar_pkg::PORT_100FD);
      if (op == OP_START) begin
        restart_nway(an_rb, mode_rb, phy, r);
      end else if (negotiating && !resolved) begin
        if (phy[14:12] == lar_pkg::NWAY_DONE) begin
          common = phy[24:16] & 9'h1E0 & adv_mask;
          resolved = 1'b1;
          if (common[8]) port_sel = lar_pkg::PORT_100FD;
          else if (common[7]) port_sel = lar_pkg::PORT_100HD;
          else if (common[6]) port_sel = lar_pkg::PORT_10FD;
          else if (common[5]) port_sel = lar_pkg::PORT_10HD;
          else begin
            // nothing in common: stay unresolved, try 100HD if that link is up
            resolved = 1'b0;
            if (!phy[1] && (adv_mask[8] || adv_mask[7])) port_sel = lar_pkg::PORT_100HD;
          end
          full_dup = (port_sel == lar_pkg::PORT_10FD) || (port_sel == lar_pkg::PORT_100FD);
          md = mode_rb & lar_pkg::MODE_KEEP;
          md |= port_sel[0] ? lar_pkg::MODE_100 : lar_pkg::MODE_10;
          if (full_dup) md |= lar_pkg::MODE_FD;
          r.autoneg_write = 1'b1;
          r.autoneg_value = an_rb & lar_pkg::AN_OFF_MASK;
          r.mode_write = 1'b1;
          r.mode_value = md;
          r.sia_reset_write = 1'b1;
          r.rxtx_action = lar_pkg::RXTX_START;
        end else begin
          port_sel = lar_pkg::PORT_10HD;
          negotiating = 1'b0;
          resolved = 1'b1;
          drop_to_10hd(an_rb, mode_rb, r);
        end
      end else if ((resolved && isr[lar_pkg::ISR_LNKCHG_BIT] && is100 && phy[1]) ||
                   (negotiating && isr[FAIL_BIT])) begin
        restart_nway(an_rb, mode_rb, phy, r);
        r.rearm_timer = 1'b1;
      end else if (is100 || port_sel == lar_pkg::PORT_10HD ||
                   port_sel == lar_pkg::PORT_10FD) begin
        beat_fail = is100 ? phy[1] : phy[2];
        negotiating = 1'b0;
        resolved = 1'b1;
        if (beat_fail && !lock) begin
          restart_nway(an_rb, mode_rb, phy, r);
          r.rearm_timer = 1'b1;
        end
      end else begin
        port_sel = lar_pkg::PORT_10HD;
        drop_to_10hd(an_rb, mode_rb, r);
      end
      r.port_out = port_sel;
      r.duplex_out = full_dup;
      expected_writes.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task compare(string name, logic [31:0] got, logic [31:0] exp);
      if (got !== exp)
        report_mismatch($sformatf("word %0d %s: got %h expected %h", results_checked, name,
                                  got, exp));
    endtask

    task check_result(logic [lar_pkg::OutDataW-1:0] d);
      lar_pkg::result_t e;
      if (expected_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", d));
        return;
      end
      e = expected_writes.pop_front();
      compare("port_out", 32'(d[2:0]), 32'(e.port_out));
      compare("duplex_out", 32'(d[3]), 32'(e.duplex_out));
      compare("autoneg_write", 32'(d[4]), 32'(e.autoneg_write));
      compare("autoneg_value", d[36:5], e.autoneg_value);
      compare("mode_write", 32'(d[37]), 32'(e.mode_write));
      compare("mode_value", d[69:38], e.mode_value);
      compare("phy_write", 32'(d[70]), 32'(e.phy_write));
      compare("phy_value", d[102:71], e.phy_value);
      compare("sia_reset_write", 32'(d[103]), 32'(e.sia_reset_write));
      compare("rxtx_action", 32'(d[105:104]), 32'(e.rxtx_action));
      compare("rearm_timer", 32'(d[106]), 32'(e.rearm_timer));
      results_checked++;
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [lar_pkg::InDataW-1:0]  in_tdata = '0;
  logic                         in_tuser = 1'b0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [lar_pkg::OutDataW-1:0] out_tdata;
  logic                         cfg_we = 1'b0;
  logic [lar_pkg::CfgIdxW-1:0]  cfg_addr = '0;
  logic [lar_pkg::AdvW-1:0]     cfg_wdata = '0;

  autoneg_checker sb = new();
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_left = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int words_sent = 0;
  int settings_used = 1;

  link_autoneg_resolver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.predict_event(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64],
                         in_tdata[127:96]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // receiver: random stalls plus a single long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 80;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  task automatic send_word(logic op, logic [31:0] isr, logic [31:0] phy,
                           logic [31:0] mode_rb, logic [31:0] an_rb);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {an_rb, mode_rb, phy, isr};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [lar_pkg::CfgIdxW-1:0] idx, logic [lar_pkg::AdvW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [lar_pkg::AdvW-1:0] adv, logic lock);
    drain();
    write_reg(lar_pkg::REG_ADVERTISE, adv);
    write_reg(lar_pkg::REG_MEDIA_LOCK, {{(lar_pkg::AdvW-1){1'b0}}, lock});
    settings_used++;
  endtask

  function automatic logic [31:0] rand_phy(int done_pct);
    logic [31:0] p;
    p = $urandom;
    if ($urandom_range(99) < done_pct) p[14:12] = lar_pkg::NWAY_DONE;
    return p;
  endfunction

  function automatic logic [31:0] rand_isr();
    logic [31:0] v;
    v = $urandom;
    v[lar_pkg::ISR_LNKCHG_BIT] = 1'($urandom_range(1));
    v[FAIL_BIT] = ($urandom_range(99) < 25);
    return v;
  endfunction

  // start, negotiation result, then one to four link events; some pure noise words
  task automatic run_episode();
    int n;
    if ($urandom_range(99) < 15) begin
      send_word(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
      return;
    end
    send_word(OP_START, $urandom, $urandom, $urandom, $urandom);
    send_word(OP_LINK, rand_isr(), rand_phy(80), $urandom, $urandom);
    n = $urandom_range(1, 4);
    repeat (n) send_word(OP_LINK, rand_isr(), rand_phy(20), $urandom, $urandom);
  endtask

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [lar_pkg::AdvW-1:0] adv_set[6];
    logic                     lock_set[6];
    int                       first;
    bit                       held;
    bit                       paused;
    adv_set = '{9'h1FF, 9'h000, 9'h100, 9'h0A0, 9'h000, 9'h1E0};
    lock_set = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    adv_set[4] = 9'($urandom_range(511));
    lock_set[4] = 1'($urandom_range(1));
    held = 1'b0;
    paused = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings
    send_word(OP_LINK, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_LINK, 32'h0, 32'h01E0_5000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_LINK, 32'h0800_0000, 32'h0000_0002, 32'h1234_5678, 32'h8765_4321);
    send_word(OP_LINK, 32'h0, 32'h0080_5000, 32'h0, 32'h0);
    send_word(OP_LINK, 32'h0000_0010, 32'h0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_word(OP_LINK, 32'h0, 32'h0040_5000, 32'h0, 32'hFFFF_FFFF);
    send_word(OP_LINK, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(OP_LINK, 32'h0, 32'h0000_0004, 32'hFFFF_FFFF, 32'h0);
    send_word(OP_LINK, 32'h0, 32'h0020_5000, 32'h0, 32'h0);
    send_word(OP_START, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(OP_LINK, 32'h0, 32'h0000_7000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_START, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(OP_LINK, 32'h0, 32'h001F_5000, 32'h0, 32'h0);
    send_word(OP_LINK, 32'h0, 32'h0000_5002, 32'h0, 32'h0);
    send_word(OP_LINK, 32'h0000_0010, 32'h0000_0000, 32'h0, 32'h0);

    // directed, nothing advertised and media locked
    configure(9'h000, 1'b1);
    send_word(OP_START, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(OP_LINK, 32'h0, 32'h01E0_5002, 32'h0, 32'h0);
    send_word(OP_LINK, 32'h0, 32'h0000_3000, 32'h0, 32'h0);
    send_word(OP_LINK, 32'h0, 32'h0000_0004, 32'h0, 32'h0);

    // directed, all advertised and media locked
    configure(9'h1FF, 1'b1);
    send_word(OP_START, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(OP_LINK, 32'h0, 32'h0100_5000, 32'h0, 32'h0);
    send_word(OP_LINK, 32'h0800_0000, 32'h0000_0002, 32'h0, 32'h0);
    send_word(OP_LINK, 32'h0, 32'h0080_5000, 32'h0, 32'h0);
    send_word(OP_LINK, 32'h0, 32'h0000_0002, 32'h0, 32'h0);

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      configure(adv_set[ph], lock_set[ph]);
      if (ph < 2) begin
        snd_idle_pct = 8;
        rcv_idle_pct = 54;
      end else if (ph < 4) begin
        snd_idle_pct = 54;
        rcv_idle_pct = 8;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      first = words_sent;
      while (words_sent - first < 100) begin
        run_episode();
        if (ph == 1 && !held && words_sent - first > 50) begin
          hold_req++;
          held = 1'b1;
        end
        if (ph == 3 && !paused && words_sent - first > 50) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Covered %0d words in, %0d results checked, %0d register settings, %0d mismatches",
             words_sent, sb.results_checked, settings_used, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/lar_pkg.sv
rtl/lar_core.sv
rtl/link_autoneg_resolver.sv
sim/tb_link_autoneg_resolver.sv
